/* rtl/tsf_pkg.sv */
// Shared types and constants of the TCP server connection state machine.
package tsf_pkg;

    localparam int SEQ_W = 32;
    localparam int LEN_W = 16;

    typedef enum logic [2:0] {
        ST_CLOSED    = 3'd0,
        ST_SYN_RCVD  = 3'd1,
        ST_ESTAB     = 3'd2,
        ST_FIN_WAIT1 = 3'd3,
        ST_FIN_WAIT2 = 3'd4
    } conn_state_t;

    typedef enum logic [1:0] {
        KIND_SYNACK = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_ANSWER = 2'd2
    } seg_kind_t;

    // One accepted segment's worth of replies, one or two of them
    typedef struct packed {
        logic              two;
        seg_kind_t         kind0;
        logic [SEQ_W-1:0]  ack0;
        seg_kind_t         kind1;
        logic [SEQ_W-1:0]  ack1;
        logic [SEQ_W-1:0]  seq;
        conn_state_t       state;
    } tsf_entry_t;

endpackage

/* rtl/tsf_if.sv */
// Channel interfaces: received segment headers in, segments to send out.
interface tsf_in_if;
    logic        valid;
    logic        ready;
    logic        syn_flag;
    logic        ack_flag;
    logic        fin_flag;
    logic        rst_flag;
    logic [31:0] remote_seq;
    logic [31:0] remote_ack;
    logic [15:0] payload_len;
    logic [31:0] initial_seq;

    modport source (
        output valid, syn_flag, ack_flag, fin_flag, rst_flag,
               remote_seq, remote_ack, payload_len, initial_seq,
        input  ready
    );
    modport sink (
        input  valid, syn_flag, ack_flag, fin_flag, rst_flag,
               remote_seq, remote_ack, payload_len, initial_seq,
        output ready
    );
endinterface

interface tsf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  segment_kind;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [2:0]  conn_state;
    logic        last;

    modport source (
        output valid, segment_kind, seq_number, ack_number, conn_state, last,
        input  ready
    );
    modport sink (
        input  valid, segment_kind, seq_number, ack_number, conn_state, last,
        output ready
    );
endinterface

/* rtl/tcp_server_connection_fsm.sv */
// Top level of the single-connection passive TCP responder.
//
// rx_seg carries one received segment header per beat: flags, remote
// sequence and acknowledgment numbers, payload length and a fresh initial
// sequence number. tx_seg carries the segments to send, zero to two per
// received beat (SYN+ACK, ACK, or the request answer), each with our
// sequence and acknowledgment numbers, the connection state after the
// whole received segment, and last set on the final reply of that segment.
// The front end takes a beat every cycle while the reply queue has room and
// updates the connection state in that same cycle; the back end sends one
// reply beat per cycle from a registered output while tx_seg is ready. A
// reply is written into the queue and then loaded into the output register
// before it appears on tx_seg. Sustained rate is one received beat per cycle
// while tx_seg is ready; a beat with two replies holds the output for both.
// Reset puts the connection in closed with both numbers at zero and empties
// the queue. When tx_seg stalls, replies collect in the queue; once it holds
// QUEUE_DEPTH entries, rx_seg ready drops until the back end loads the last
// reply of the oldest entry into its output register and frees its slot.
module tcp_server_connection_fsm #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    tsf_in_if.sink    rx_seg,
    tsf_out_if.source tx_seg
);
    import tsf_pkg::*;

    tsf_entry_t push_entry;
    tsf_entry_t head;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    tsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_seg),
        .q_full     (full),
        .push       (push),
        .push_entry (push_entry)
    );

    tsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    tsf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .tx    (tx_seg)
    );

endmodule

/* rtl/tsf_front.sv */
// Front end: accepts segment headers, runs the connection state machine,
// and queues the replies each segment causes.
module tsf_front (
    input  logic               clk,
    input  logic               rst_n,
    tsf_in_if.sink             rx,
    input  logic               q_full,
    output logic               push,
    output tsf_pkg::tsf_entry_t push_entry
);
    import tsf_pkg::*;

    conn_state_t       state_reg, state_next, st_eff, st_step;
    logic [SEQ_W-1:0]  seq_reg, seq_next, seq_step;
    logic [SEQ_W-1:0]  ack_reg, ack_next, ack_step;
    logic [SEQ_W-1:0]  plus_one, plus_len;
    logic [1:0]        n_res;
    logic              has_data;
    logic              accept;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    assign plus_one = rx.remote_seq + 32'd1;
    assign plus_len = rx.remote_seq + {16'd0, rx.payload_len};
    assign has_data = rx.ack_flag && (rx.payload_len != 16'd0);

    // Next state: a SYN in established or any closing state restarts from closed
    always_comb
    begin
        st_eff = state_reg;
        if (rx.syn_flag && state_reg != ST_CLOSED && state_reg != ST_SYN_RCVD)
        begin
            st_eff = ST_CLOSED;
        end
        case (st_eff)
            ST_CLOSED:
            begin
                st_step = rx.syn_flag ? ST_SYN_RCVD : ST_CLOSED;
            end
            ST_SYN_RCVD:
            begin
                if (rx.rst_flag)
                    st_step = ST_CLOSED;
                else if (rx.ack_flag)
                    st_step = has_data ? ST_FIN_WAIT1 : ST_ESTAB;
                else
                    st_step = ST_SYN_RCVD;
            end
            ST_ESTAB:
            begin
                if (rx.rst_flag || rx.fin_flag)
                    st_step = ST_CLOSED;
                else if (rx.ack_flag)
                    st_step = has_data ? ST_FIN_WAIT1 : ST_ESTAB;
                else
                    st_step = ST_ESTAB;
            end
            ST_FIN_WAIT1:
            begin
                if (rx.fin_flag)
                    st_step = ST_CLOSED;
                else if (rx.ack_flag)
                    st_step = ST_FIN_WAIT2;
                else
                    st_step = ST_FIN_WAIT1;
            end
            ST_FIN_WAIT2:
            begin
                st_step = rx.fin_flag ? ST_CLOSED : ST_FIN_WAIT2;
            end
            default:
            begin
                st_step = ST_CLOSED;
            end
        endcase
        state_next = accept ? st_step : state_reg;
    end

    // Outputs: number updates and the replies to queue
    always_comb
    begin
        seq_step         = seq_reg;
        ack_step         = ack_reg;
        n_res            = 2'd0;
        push_entry.kind0 = KIND_ACK;
        push_entry.ack0  = ack_reg;
        push_entry.kind1 = KIND_ACK;
        push_entry.ack1  = ack_reg;
        case (st_eff)
            ST_CLOSED:
            begin
                if (rx.syn_flag)
                begin
                    seq_step         = rx.initial_seq;
                    ack_step         = plus_one;
                    n_res            = 2'd1;
                    push_entry.kind0 = KIND_SYNACK;
                    push_entry.ack0  = plus_one;
                end
            end
            ST_SYN_RCVD:
            begin
                if (!rx.rst_flag && rx.ack_flag)
                begin
                    seq_step = rx.remote_ack;
                    if (has_data)
                    begin
                        ack_step         = plus_len;
                        n_res            = 2'd1;
                        push_entry.kind0 = KIND_ANSWER;
                        push_entry.ack0  = plus_len;
                    end
                end
            end
            ST_ESTAB:
            begin
                if (!rx.rst_flag)
                begin
                    if (rx.ack_flag)
                        seq_step = rx.remote_ack;
                    if (has_data)
                    begin
                        ack_step         = plus_len;
                        n_res            = 2'd1;
                        push_entry.kind0 = KIND_ANSWER;
                        push_entry.ack0  = plus_len;
                    end
                    if (rx.fin_flag)
                    begin
                        ack_step = plus_one;
                        if (has_data)
                        begin
                            n_res            = 2'd2;
                            push_entry.kind1 = KIND_ACK;
                            push_entry.ack1  = plus_one;
                        end
                        else
                        begin
                            n_res            = 2'd1;
                            push_entry.kind0 = KIND_ACK;
                            push_entry.ack0  = plus_one;
                        end
                    end
                end
            end
            ST_FIN_WAIT1, ST_FIN_WAIT2:
            begin
                if (rx.fin_flag)
                begin
                    ack_step         = plus_one;
                    n_res            = 2'd1;
                    push_entry.kind0 = KIND_ACK;
                    push_entry.ack0  = plus_one;
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
        push_entry.two   = (n_res == 2'd2);
        push_entry.seq   = seq_step;
        push_entry.state = st_step;
        push             = accept && (n_res != 2'd0);
        seq_next         = accept ? seq_step : seq_reg;
        ack_next         = accept ? ack_step : ack_reg;
    end

    // Hold connection state between beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLOSED;
            seq_reg   <= '0;
            ack_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            ack_reg   <= ack_next;
        end
    end

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (rx.valid && rx.ready))
        else $error("reply queued without an accepted beat");

endmodule

/* rtl/tsf_queue.sv */
// Short queue of reply entries between the front and back ends.
module tsf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tsf_pkg::tsf_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output tsf_pkg::tsf_entry_t head,
    output logic                empty
);
    import tsf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    tsf_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full reply queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty reply queue");

endmodule

/* rtl/tsf_back.sv */
// Back end: unpacks queued entries into single segment beats.
module tsf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tsf_pkg::tsf_entry_t head,
    input  logic                empty,
    output logic                pop,
    tsf_out_if.source           tx
);
    import tsf_pkg::*;

    logic              valid_reg, valid_next;
    logic              part_reg, part_next;
    logic              load;
    logic              head_last;
    seg_kind_t         kind_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEQ_W-1:0]  ack_reg;
    conn_state_t       state_reg;
    logic              last_reg;

    assign load      = !empty && (!valid_reg || tx.ready);
    assign head_last = part_reg || !head.two;
    assign pop       = load && head_last;

    // Step through the parts of the head entry
    always_comb
    begin
        valid_next = valid_reg;
        part_next  = part_reg;
        if (load)
        begin
            valid_next = 1'b1;
            part_next  = !head_last;
        end
        else if (tx.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            part_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            part_reg  <= part_next;
        end
    end

    // Load the output beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= part_reg ? head.kind1 : head.kind0;
            ack_reg   <= part_reg ? head.ack1 : head.ack0;
            seq_reg   <= head.seq;
            state_reg <= head.state;
            last_reg  <= head_last;
        end
    end

    assign tx.valid        = valid_reg;
    assign tx.segment_kind = kind_reg;
    assign tx.seq_number   = seq_reg;
    assign tx.ack_number   = ack_reg;
    assign tx.conn_state   = state_reg;
    assign tx.last         = last_reg;

    a_second_part_waits: assert property (@(posedge clk) disable iff (!rst_n)
        part_reg |-> (!empty && head.two))
        else $error("second reply pending without a two-reply entry");

    a_first_of_two_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !part_reg && head.two) |=> (valid_reg && !last_reg && part_reg))
        else $error("first of two replies marked last");

endmodule
